// File: design/vsn_pkg.sv
package vsn_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int MAX_UNIFIED  = 65536;

  localparam int VtxW  = $clog2(MAX_VERTICES);
  localparam int NfiW  = $clog2(MAX_UNIFIED) + 1;
  localparam int OutW  = 16;
  localparam int OvcW  = 13;
  localparam int CompW = 32;

  localparam logic [CompW-1:0] AbsMask = 32'h7FFF_FFFF;
  localparam logic [CompW-1:0] ExpAll  = 32'h7F80_0000;

  typedef struct packed {
    logic [CompW-1:0] x;
    logic [CompW-1:0] y;
    logic [CompW-1:0] z;
  } normal_t;

  typedef struct packed {
    logic unset;
    logic equal;
  } match_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

endpackage

// File: design/vertex_split_by_normal.sv
// channel | handshake                  | word
// --------+----------------------------+---------------------------------------
// in      | in_valid_i / in_ready_o    | vertex_index_i, normal_x/y/z_i
// out     | out_valid_o / out_ready_i  | out_index_o, new_vertex_o,
//         |                            | source_index_o, status_o
// cfg     | psel/penable/pwrite        | paddr, pwdata -> original_vertex_count
//
// The edge that takes a word also reads its table entry; the lookup stage then
// compares it and registers the result once the output register is free, raising
// out_valid_o. While the output is taken, one word per cycle is sustained through
// the single table read-modify-write (a write to the entry read at the same edge is
// forwarded). After reset the table is swept to zero, one entry a cycle, through
// all MAX_VERTICES (4096) entries; no word is taken until the sweep ends.
// A full output register that is not taken stalls the lookup stage and the input.
module vertex_split_by_normal import vsn_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [VtxW-1:0]     vertex_index_i,
  input  logic [CompW-1:0]    normal_x_i,
  input  logic [CompW-1:0]    normal_y_i,
  input  logic [CompW-1:0]    normal_z_i,

  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutW-1:0]     out_index_o,
  output logic                new_vertex_o,
  output logic [VtxW-1:0]     source_index_o,
  output logic [1:0]          status_o,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic            clr_q;
  logic [VtxW-1:0] clr_addr_q;

  logic [OvcW-1:0] ovc_q;
  logic [NfiW-1:0] nfi_q, nfi_d;

  logic            s1_valid_q;
  logic [VtxW-1:0] s1_vi_q;
  normal_t         s1_n_q;
  logic            fwd_q;
  normal_t         fwd_data_q;

  logic            out_valid_q;
  logic [OutW-1:0] out_index_q;
  logic            new_vertex_q;
  logic [VtxW-1:0] source_index_q;
  status_e         status_q;

  logic            cfg_wr;
  logic            in_fire, s1_fire;
  normal_t         rd_data, entry;
  match_t          match;

  logic            tab_we;
  logic [VtxW-1:0] tab_waddr;
  normal_t         tab_wdata;
  logic            upd_we;

  logic            oor, full;
  logic [OutW-1:0] res_index;
  logic            res_new;
  status_e         res_status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {{(32-OvcW){1'b0}}, ovc_q} : '0;

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_q && (!s1_valid_q || s1_fire);
  assign in_fire    = in_valid_i && in_ready_o;

  assign entry = fwd_q ? fwd_data_q : rd_data;

  vsn_match u_match (
    .entry_i  (entry),
    .normal_i (s1_n_q),
    .match_o  (match)
  );

  always_comb begin
    oor = ({1'b0, s1_vi_q} >= ovc_q) || (32'(s1_vi_q) >= 32'(MAX_VERTICES));
    full = nfi_q >= NfiW'(MAX_UNIFIED);
    upd_we = 1'b0;
    nfi_d = nfi_q;
    res_index = '0;
    res_new = 1'b0;
    res_status = STAT_OK;
    priority if (oor) begin
      res_status = STAT_RANGE;
    end else if (match.unset) begin
      upd_we = s1_fire;
      res_index = OutW'(s1_vi_q);
    end else if (match.equal) begin
      res_index = OutW'(s1_vi_q);
    end else if (full) begin
      res_status = STAT_FULL;
    end else begin
      res_index = nfi_q[OutW-1:0];
      res_new = 1'b1;
      if (s1_fire) begin
        nfi_d = nfi_q + NfiW'(1);
      end
    end
    if (cfg_wr) begin
      nfi_d = NfiW'(pwdata[OvcW-1:0]);
    end
  end

  // sweep owns the write port until the table is clear
  always_comb begin
    if (clr_q) begin
      tab_we    = 1'b1;
      tab_waddr = clr_addr_q;
      tab_wdata = '0;
    end else begin
      tab_we    = upd_we;
      tab_waddr = s1_vi_q;
      tab_wdata = s1_n_q;
    end
  end

  vsn_ram #(
    .Width ($bits(normal_t)),
    .Depth (MAX_VERTICES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (tab_wdata),
    .re_i    (in_fire),
    .raddr_i (vertex_index_i),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      ovc_q      <= '0;
      nfi_q      <= '0;
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + VtxW'(1);
        if (clr_addr_q == VtxW'(MAX_VERTICES - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (cfg_wr) begin
        ovc_q <= pwdata[OvcW-1:0];
      end
      nfi_q <= nfi_d;
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_vi_q    <= vertex_index_i;
      s1_n_q     <= '{x: normal_x_i, y: normal_y_i, z: normal_z_i};
      // catch the entry being written back as it is read
      fwd_q      <= upd_we && (s1_vi_q == vertex_index_i);
      fwd_data_q <= s1_n_q;
    end
    if (s1_fire) begin
      out_index_q    <= res_index;
      new_vertex_q   <= res_new;
      source_index_q <= s1_vi_q;
      status_q       <= res_status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_index_o    = out_index_q;
  assign new_vertex_o   = new_vertex_q;
  assign source_index_o = source_index_q;
  assign status_o       = status_q;

endmodule

// File: design/vsn_ram.sv
module vsn_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: design/vsn_match.sv
module vsn_match import vsn_pkg::*; (
  input  normal_t entry_i,
  input  normal_t normal_i,
  output match_t  match_o
);

  function automatic logic comp_zero(input logic [CompW-1:0] a);
    comp_zero = (a & AbsMask) == '0;
  endfunction

  function automatic logic comp_eq(input logic [CompW-1:0] a, input logic [CompW-1:0] b);
    logic nan;
    nan = ((a & AbsMask) > ExpAll) || ((b & AbsMask) > ExpAll);
    comp_eq = !nan && ((comp_zero(a) && comp_zero(b)) || (a == b));
  endfunction

  always_comb begin
    match_o.unset = comp_zero(entry_i.x) && comp_zero(entry_i.y) && comp_zero(entry_i.z);
    match_o.equal = comp_eq(entry_i.x, normal_i.x) && comp_eq(entry_i.y, normal_i.y)
                    && comp_eq(entry_i.z, normal_i.z);
  end

endmodule

// File: bench/tb_vertex_split_by_normal.sv
`timescale 1ns / 100ps

module tb_vertex_split_by_normal;
  import vsn_pkg::*;

  localparam logic [2:0] OVC_ADDR     = 3'd0;
  localparam int         CYCLE_LIMIT  = 1_000_000;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [OutW-1:0] out_index;
    logic            new_vertex;
    logic [VtxW-1:0] source_index;
    status_e         status;
  } corner_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic             in_valid_i;
  logic             in_ready_o;
  logic [VtxW-1:0]  vertex_index_i;
  logic [CompW-1:0] normal_x_i;
  logic [CompW-1:0] normal_y_i;
  logic [CompW-1:0] normal_z_i;

  logic             out_valid_o;
  logic             out_ready_i;
  logic [OutW-1:0]  out_index_o;
  logic             new_vertex_o;
  logic [VtxW-1:0]  source_index_o;
  logic [1:0]       status_o;

  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  vertex_split_by_normal dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .vertex_index_i (vertex_index_i),
    .normal_x_i     (normal_x_i),
    .normal_y_i     (normal_y_i),
    .normal_z_i     (normal_z_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_index_o    (out_index_o),
    .new_vertex_o   (new_vertex_o),
    .source_index_o (source_index_o),
    .status_o       (status_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the block state
  normal_t         seen_normal [MAX_VERTICES];
  logic [NfiW-1:0] free_index;
  logic [OvcW-1:0] vertex_count;

  corner_result_t corner_results_due [$];

  int mismatches   = 0;
  int cycles       = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int rx_hold_left = 0;

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  function automatic logic comp_nan(input logic [CompW-1:0] a);
    return (a & AbsMask) > ExpAll;
  endfunction

  function automatic logic comp_zero(input logic [CompW-1:0] a);
    return (a & AbsMask) == '0;
  endfunction

  function automatic logic comp_same(input logic [CompW-1:0] a, input logic [CompW-1:0] b);
    if (comp_nan(a) || comp_nan(b)) return 1'b0;
    if (comp_zero(a) && comp_zero(b)) return 1'b1;
    return a == b;
  endfunction

  function automatic corner_result_t split_corner(input logic [VtxW-1:0] vi, input normal_t n);
    corner_result_t r;
    normal_t        e;
    r.out_index    = '0;
    r.new_vertex   = 1'b0;
    r.source_index = vi;
    r.status       = STAT_OK;
    if ({1'b0, vi} >= vertex_count) begin
      r.status = STAT_RANGE;
      return r;
    end
    e = seen_normal[vi];
    if (comp_zero(e.x) && comp_zero(e.y) && comp_zero(e.z)) begin
      seen_normal[vi] = n;
      r.out_index = OutW'(vi);
    end else if (comp_same(e.x, n.x) && comp_same(e.y, n.y) && comp_same(e.z, n.z)) begin
      r.out_index = OutW'(vi);
    end else if (free_index >= MAX_UNIFIED) begin
      r.status = STAT_FULL;
    end else begin
      r.out_index  = free_index[OutW-1:0];
      r.new_vertex = 1'b1;
      free_index   = free_index + 1'b1;
    end
    return r;
  endfunction

  task automatic send_corner(input logic [VtxW-1:0] vi, input logic [CompW-1:0] nx,
                             input logic [CompW-1:0] ny, input logic [CompW-1:0] nz);
    normal_t n;
    n = {nx, ny, nz};
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    vertex_index_i <= vi;
    normal_x_i     <= nx;
    normal_y_i     <= ny;
    normal_z_i     <= nz;
    do @(posedge clk_i); while (!in_ready_o);
    corner_results_due = {corner_results_due, split_corner(vi, n)};
  endtask

  // Drop valid and let every word drain before touching the register
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (corner_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_vertex_count(input logic [OvcW-1:0] count);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= OVC_ADDR;
    pwdata  <= 32'(count);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    vertex_count = count;
    free_index   = NfiW'(count);
    // read it back
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(count))
      log_mismatch($sformatf("vertex count read back: expected %0d, got %0d", count, prdata));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [CompW-1:0] pick_special();
    case ($urandom_range(6))
      0:       return 32'h0000_0000;
      1:       return 32'h8000_0000;
      2:       return 32'h7F80_0000;
      3:       return 32'hFF80_0000;
      4:       return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(23'h7F_FFFF, 1))};
      5:       return 32'h3F80_0000;
      default: return {1'($urandom_range(1)), 31'($urandom_range(1, 0))};
    endcase
  endfunction

  task automatic send_random_corners(input int count, input int hot_span);
    int              sel;
    int              b;
    logic [VtxW-1:0] vi;
    normal_t         n;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        vi = VtxW'($urandom_range(hot_span - 1));
      end else if (sel < 90) begin
        vi = VtxW'($urandom);
      end else begin
        b = int'(vertex_count) - int'($urandom_range(1));
        if (b < 0) b = 0;
        if (b > MAX_VERTICES - 1) b = MAX_VERTICES - 1;
        vi = VtxW'(b);
      end
      sel = $urandom_range(99);
      if (sel < 45) begin
        // repeat the stored normal, giving any zero a random sign
        n = seen_normal[vi];
        if (comp_zero(n.x)) n.x[31] = 1'($urandom_range(1));
        if (comp_zero(n.y)) n.y[31] = 1'($urandom_range(1));
        if (comp_zero(n.z)) n.z[31] = 1'($urandom_range(1));
      end else if (sel < 60) begin
        n.x = {1'($urandom_range(1)), 31'd0};
        n.y = {1'($urandom_range(1)), 31'd0};
        n.z = {1'($urandom_range(1)), 31'd0};
      end else if (sel < 75) begin
        n = {pick_special(), pick_special(), pick_special()};
      end else begin
        n = {32'($urandom), 32'($urandom), 32'($urandom)};
      end
      send_corner(vi, n.x, n.y, n.z);
    end
  endtask

  task automatic test_range_at_reset();
    write_vertex_count(13'd0);
    send_corner(12'd0, 32'h3F80_0000, 32'h0, 32'h0);
    send_corner(12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_corner(VtxW'($urandom), 32'($urandom), 32'($urandom), 32'($urandom));
  endtask

  task automatic test_directed_cases();
    wait_idle();
    write_vertex_count(13'd4096);
    send_corner(12'd0, 32'h3F80_0000, 32'h0000_0000, 32'h0000_0000);
    send_corner(12'd0, 32'h3F80_0000, 32'h0000_0000, 32'h0000_0000);
    send_corner(12'd0, 32'h0000_0000, 32'h3F80_0000, 32'h0000_0000);
    send_corner(12'd0, 32'h3F80_0000, 32'h8000_0000, 32'h0000_0000);
    // zero normals leave the entry unset
    send_corner(12'd1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_corner(12'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_corner(12'd1, 32'h0000_0001, 32'h8000_0001, 32'h7F80_0000);
    send_corner(12'd1, 32'h8000_0001, 32'h8000_0001, 32'h7F80_0000);
    send_corner(12'd1, 32'h0000_0001, 32'h8000_0001, 32'h7F80_0000);
    // a stored NaN never matches
    send_corner(12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_corner(12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_corner(12'd2, 32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF);
    send_corner(12'd2, 32'h7F80_0001, 32'hFF80_0000, 32'h7F7F_FFFF);
    send_corner(12'd2, 32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF);
    wait_idle();
    write_vertex_count(13'd5);
    send_corner(12'd5, 32'h3F80_0000, 32'h0, 32'h0);
    send_corner(12'd4, 32'hBF80_0000, 32'h3F00_0000, 32'h0);
    send_corner(12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_idle();
    write_vertex_count(13'd1);
    send_corner(12'd0, 32'h0000_0000, 32'h0000_0000, 32'h3F80_0000);
    send_corner(12'd1, 32'h3F80_0000, 32'h0, 32'h0);
  endtask

  task automatic test_output_stall();
    wait_idle();
    write_vertex_count(13'd4096);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    // hold the output off while words keep coming
    @(posedge clk_i);
    rx_hold_left = HOLD_CYCLES;
    send_random_corners(40, MAX_VERTICES);
  endtask

  task automatic test_random_traffic();
    int tx_pct [4] = '{0, 75, 0, 6};
    int rx_pct [4] = '{0, 0, 75, 6};
    int counts [4];
    int spans  [4];
    counts = '{4096, $urandom_range(4095, 1), 16, 200};
    spans  = '{64, 32, 16, 200};
    for (int m = 0; m < 4; m++) begin
      wait_idle();
      write_vertex_count(OvcW'(counts[m]));
      tx_idle_pct  = tx_pct[m];
      rx_stall_pct = rx_pct[m];
      send_random_corners(350, spans[m] < counts[m] ? spans[m] : counts[m]);
    end
  endtask

  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_ready_i  <= 1'b0;
      rx_hold_left  = rx_hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    corner_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (corner_results_due.size() == 0) begin
        log_mismatch($sformatf("unexpected word: index %0d new %0d source %0d status %0d",
                               out_index_o, new_vertex_o, source_index_o, status_o));
      end else begin
        want = corner_results_due.pop_front();
        if (out_index_o !== want.out_index || new_vertex_o !== want.new_vertex ||
            source_index_o !== want.source_index || status_o !== want.status)
          log_mismatch($sformatf(
            "expected index %0d new %0d source %0d status %0d, got %0d %0d %0d %0d",
            want.out_index, want.new_vertex, want.source_index, want.status,
            out_index_o, new_vertex_o, source_index_o, status_o));
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL vertex_split_by_normal");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    vertex_index_i = '0;
    normal_x_i     = '0;
    normal_y_i     = '0;
    normal_z_i     = '0;
    out_ready_i    = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    for (int i = 0; i < MAX_VERTICES; i++) seen_normal[i] = '0;
    free_index   = '0;
    vertex_count = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_range_at_reset();
    test_directed_cases();
    test_output_stall();
    test_random_traffic();
    wait_idle();

    if (mismatches == 0) begin
      $display("PASS vertex_split_by_normal");
    end else begin
      $display("FAIL vertex_split_by_normal");
    end
    $finish;
  end

endmodule

// File: vertex_split_by_normal.f
design/vsn_pkg.sv
design/vsn_ram.sv
design/vsn_match.sv
design/vertex_split_by_normal.sv
bench/tb_vertex_split_by_normal.sv
